@@ rtl/core/bprf_pkg.sv @@
// ---------------------------------------------------------------------------
// bprf_pkg
// Types and codes shared by the byte pipe ring FIFO modules.
// ---------------------------------------------------------------------------
package bprf_pkg;

    localparam logic [1:0] ACT_WRITE        = 2'd0;
    localparam logic [1:0] ACT_READ         = 2'd1;
    localparam logic [1:0] ACT_CLOSE_WRITER = 2'd2;
    localparam logic [1:0] ACT_CLOSE_READER = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_WAIT_FULL  = 3'd1;
    localparam logic [2:0] ST_WAIT_EMPTY = 3'd2;
    localparam logic [2:0] ST_EOF        = 3'd3;
    localparam logic [2:0] ST_BROKEN     = 3'd4;
    localparam logic [2:0] ST_SHORT      = 3'd5;
    localparam logic [2:0] ST_CLOSED     = 3'd6;

    localparam int FILL_W = 12;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] write_byte;
        logic       last_of_transfer;
    } in_word_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [7:0]        read_byte;
        logic [FILL_W-1:0] fill_level;
    } out_word_t;

endpackage

@@ rtl/core/byte_pipe_ring_fifo_unit.sv @@
// ---------------------------------------------------------------------------
// byte_pipe_ring_fifo_unit
// One-way byte pipe on a ring buffer; one action per word, one result word.
// ---------------------------------------------------------------------------
//  channel | direction | handshake         | word
//  s_      | in        | s_valid / s_ready | in_word_t  (action, byte, last)
//  m_      | out       | m_valid / m_ready | out_word_t (status, byte, fill)
//
//  One word per cycle while m_ready does not stall the output; a result
//  passes the decision stage with RAM read, then the output register.
//  The ring RAM read port sets the first stage: read data lands with it.
//  Reset clears pointers, count, end flags and both valid bits; no RAM sweep.
//  A stalled result waits in the output register while one more word is
//  taken into the decision stage.
// ---------------------------------------------------------------------------
module byte_pipe_ring_fifo_unit
    import bprf_pkg::*;
#(
    parameter int DEPTH = 4096,
    localparam int PTR_W = $clog2(DEPTH)
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] count_reg,  count_next;
    logic             writer_open_reg, writer_open_next;
    logic             reader_open_reg, reader_open_next;
    logic             wip_reg, wip_next;
    logic             rip_reg, rip_next;

    logic             p_valid_reg;
    logic [2:0]       p_status_reg;
    logic [PTR_W-1:0] p_count_reg;
    logic             p_hit_reg;

    logic             o_valid_reg;
    out_word_t        o_word_reg;

    logic             accept;
    logic             p_advance;
    logic             wr_hit;
    logic             rd_hit;
    logic [2:0]       status_next;
    logic [7:0]       ram_q;
    out_word_t        p_word;
    logic [PTR_W+FILL_W-1:0] fill_ext;

    assign p_advance = p_valid_reg && (!o_valid_reg || m_ready);
    assign s_ready   = !p_valid_reg || p_advance;
    assign accept    = s_valid && s_ready;

    always_comb begin
        status_next      = ST_OK;
        wr_hit           = 1'b0;
        rd_hit           = 1'b0;
        writer_open_next = writer_open_reg;
        reader_open_next = reader_open_reg;
        wip_next         = wip_reg;
        rip_next         = rip_reg;
        unique case (s_data.action)
            ACT_WRITE: begin
                if (!writer_open_reg) begin
                    status_next = ST_CLOSED;
                end else if (!reader_open_reg) begin
                    status_next = wip_reg ? ST_SHORT : ST_BROKEN;
                    wip_next    = 1'b0;
                end else if (count_reg == PTR_LAST) begin
                    status_next = ST_WAIT_FULL;
                end else begin
                    wr_hit   = 1'b1;
                    wip_next = !s_data.last_of_transfer;
                end
            end
            ACT_READ: begin
                if (!reader_open_reg) begin
                    status_next = ST_CLOSED;
                end else if (count_reg != '0) begin
                    rd_hit   = 1'b1;
                    rip_next = !s_data.last_of_transfer;
                end else if (rip_reg) begin
                    status_next = ST_SHORT;
                    rip_next    = 1'b0;
                end else if (!writer_open_reg) begin
                    status_next = ST_EOF;
                end else begin
                    status_next = ST_WAIT_EMPTY;
                end
            end
            ACT_CLOSE_WRITER: begin
                if (!writer_open_reg) begin
                    status_next = ST_CLOSED;
                end else begin
                    writer_open_next = 1'b0;
                    wip_next         = 1'b0;
                end
            end
            ACT_CLOSE_READER: begin
                if (!reader_open_reg) begin
                    status_next = ST_CLOSED;
                end else begin
                    reader_open_next = 1'b0;
                    rip_next         = 1'b0;
                end
            end
            default: begin
                status_next = ST_CLOSED;
            end
        endcase
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_hit) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        if (rd_hit) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    bprf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (accept && wr_hit),
        .wr_addr (wr_ptr_reg),
        .wr_data (s_data.write_byte),
        .rd_en   (accept && rd_hit),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
            writer_open_reg <= 1'b1;
            reader_open_reg <= 1'b1;
            wip_reg         <= 1'b0;
            rip_reg         <= 1'b0;
        end else if (accept) begin
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
            count_reg       <= count_next;
            writer_open_reg <= writer_open_next;
            reader_open_reg <= reader_open_next;
            wip_reg         <= wip_next;
            rip_reg         <= rip_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (s_ready) begin
            p_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_status_reg <= status_next;
            p_count_reg  <= count_next;
            p_hit_reg    <= rd_hit;
        end
    end

    assign fill_ext             = {{FILL_W{1'b0}}, p_count_reg};
    assign p_word.status        = p_status_reg;
    assign p_word.read_byte     = p_hit_reg ? ram_q : 8'd0;
    assign p_word.fill_level    = fill_ext[FILL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (!o_valid_reg || m_ready) begin
            o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_advance) begin
            o_word_reg <= p_word;
        end
    end

    assign m_valid = o_valid_reg;
    assign m_data  = o_word_reg;

endmodule

@@ rtl/core/bprf_ram.sv @@
// ---------------------------------------------------------------------------
// bprf_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bprf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
